/* rtl/lru_page_replacement_macros.svh */
// Assertion macros shared by the LRU page replacement checker.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRUPR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru_page_replacement: implication check failed");

// Next-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru_page_replacement: next-cycle check failed");

`endif

/* rtl/lrupr_pkg.sv */
// Shared constants, types and bus layouts of the LRU page replacement block.
`default_nettype none

package lrupr_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int PAGE_BITS  = 20;
   localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
   localparam int CNT_W      = 16;
   localparam int CFG_W      = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_FRAMES - 1);

   // Request tdata: page number, zero filled to whole bytes.
   localparam int REQ_TDATA_W = ((PAGE_BITS + 7) / 8) * 8;

   // Response tdata layout, lowest bit first.
   localparam int RSP_FAULT_BIT = 0;
   localparam int RSP_EVV_BIT   = 1;
   localparam int RSP_EVP_LSB   = 2;
   localparam int RSP_CNT_LSB   = RSP_EVP_LSB + PAGE_BITS;
   localparam int RSP_USED_W    = RSP_CNT_LSB + CNT_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [IDX_W-1:0]     rank_type;

   typedef struct packed {
      logic    load;
      logic    scan;
      idx_type scan_idx;
      logic    commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/lru_page_replacement.sv */
// Top level of the fully associative LRU page replacement tracker.
//
//   channel | direction | tdata (low bit first)                         | tlast
//   --------+-----------+-----------------------------------------------+--------------------
//   req_    | in        | page_number[19:0], zero fill to 24 bits       | last_reference
//   rsp_    | out       | page_fault, evicted_valid, evicted_page[19:0],| sequence_done
//           |           | fault_count[15:0], zero fill to 40 bits       |
//   csr_    | in        | frames_in_use[4:0] on csr_wr_data             | -
//
// Each transaction is accepted, then walks all the frames one per cycle through the single
// read port of the page store, and then commits its update.
// The next transaction is accepted as soon as the update is done, even while the
// previous result still waits in the output register.
// The update cycle stalls only while the output register holds an untaken result.
// Reset is synchronous: all frames empty, fault count zero, limit four frames;
// the block accepts in the first cycle after reset falls.
`default_nettype none

module lru_page_replacement (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = page_number[19:0], zeros above; tlast = last_reference
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lrupr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                              req_tlast,
   // configuration: frames_in_use
   input  logic                              csr_wr_en,
   input  logic [lrupr_pkg::CFG_W-1:0]       csr_wr_data,
   // response: tdata = page_fault, evicted_valid, evicted_page[19:0],
   //           fault_count[15:0], zeros above; tlast = sequence_done
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lrupr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast
);
   import lrupr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: accept a transaction, walk the frames, commit the update
   lrupr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // frame store, LRU ranks, fault counter and result register
   lrupr_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/lrupr_ctrl.sv */
// Sequencer of the LRU page replacement block: accept, frame scan, update.
`default_nettype none

module lrupr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lrupr_pkg::dp_status_type status,
   output lrupr_pkg::ctrl_cmd_type  cmd
);
   import lrupr_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   idx_type    idx_ff, idx_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.scan_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            // refuse transactions while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_UPDATE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            // hold until the result register can take the new transaction
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/lrupr_dpath.sv */
// Datapath of the LRU page replacement block: frame store, scan, update, result.
`default_nettype none

module lrupr_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lrupr_pkg::ctrl_cmd_type                cmd,
   output lrupr_pkg::dp_status_type               status,
   input  logic [lrupr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  csr_wr_en,
   input  logic [lrupr_pkg::CFG_W-1:0]           csr_wr_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lrupr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tlast
);
   import lrupr_pkg::*;

   // configuration
   logic [CFG_W-1:0] cfg_ff;
   logic [OCC_W-1:0] limit;

   // current transaction
   page_type page_ff;
   logic     last_ff;

   // frame store
   page_type                page_mem [MAX_FRAMES];
   page_type                rd_data_ff;
   idx_type                 rd_addr;
   logic [MAX_FRAMES-1:0]   valid_ff, valid_in;
   rank_type                rank_ff [MAX_FRAMES];
   rank_type                rank_in [MAX_FRAMES];

   // scan results
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             hit_ff, hit_in;
   idx_type          hit_idx_ff, hit_idx_in;
   rank_type         hit_rank_ff, hit_rank_in;
   logic             vic_ff, vic_in;
   idx_type          vic_idx_ff, vic_idx_in;
   rank_type         vic_rank_ff, vic_rank_in;
   page_type         vic_page_ff, vic_page_in;
   logic             free_ff, free_in;
   idx_type          free_idx_ff, free_idx_in;

   // update
   logic             fill;
   idx_type          slot;
   logic [CNT_W-1:0] count_ff, count_in, count_next;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic                   out_last_ff, out_last_in;

   // zero acts as one frame, anything above the store depth as the full store
   always_comb begin
      if (cfg_ff == '0) begin
         limit = OCC_W'(1);
      end else if (int'(cfg_ff) > MAX_FRAMES) begin
         limit = OCC_W'(MAX_FRAMES);
      end else begin
         limit = OCC_W'(cfg_ff);
      end
   end

   // prefetch the next frame so its page is ready in the following cycle
   always_comb begin
      rd_addr = '0;
      if (cmd.scan && (cmd.scan_idx != LAST_IDX)) begin
         rd_addr = cmd.scan_idx + 1'b1;
      end
   end

   always_comb begin
      occ_in      = occ_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rank_in = hit_rank_ff;
      vic_in      = vic_ff;
      vic_idx_in  = vic_idx_ff;
      vic_rank_in = vic_rank_ff;
      vic_page_in = vic_page_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.load) begin
         occ_in  = '0;
         hit_in  = 1'b0;
         vic_in  = 1'b0;
         free_in = 1'b0;
      end else if (cmd.scan) begin
         if (valid_ff[cmd.scan_idx]) begin
            occ_in = occ_ff + 1'b1;
            if ((rd_data_ff == page_ff) && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = cmd.scan_idx;
               hit_rank_in = rank_ff[cmd.scan_idx];
            end
            if (!vic_ff || (rank_ff[cmd.scan_idx] > vic_rank_ff)) begin
               vic_in      = 1'b1;
               vic_idx_in  = cmd.scan_idx;
               vic_rank_in = rank_ff[cmd.scan_idx];
               vic_page_in = rd_data_ff;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmd.scan_idx;
         end
      end
   end

   always_comb begin
      fill = (occ_ff < limit) && free_ff;
      if (hit_ff) begin
         slot = hit_idx_ff;
      end else if (fill) begin
         slot = free_idx_ff;
      end else begin
         slot = vic_idx_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         rank_in[i] = rank_ff[i];
         if (cmd.commit) begin
            if (last_ff) begin
               valid_in[i] = 1'b0;
               rank_in[i]  = '0;
            end else if (hit_ff) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
               if (IDX_W'(i) == slot) begin
                  rank_in[i] = '0;
               end
            end else begin
               if (valid_ff[i] && (IDX_W'(i) != slot)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
               if (IDX_W'(i) == slot) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end
            end
         end
      end
   end

   always_comb begin
      count_next = count_ff;
      if (!hit_ff && (count_ff != COUNT_MAX)) begin
         count_next = count_ff + 1'b1;
      end
      count_in = count_ff;
      if (cmd.commit) begin
         count_in = last_ff ? '0 : count_next;
      end
   end

   always_comb begin
      out_data_in                                   = '0;
      out_data_in[RSP_FAULT_BIT]                    = !hit_ff;
      out_data_in[RSP_EVV_BIT]                      = !hit_ff && !fill;
      out_data_in[RSP_EVP_LSB +: PAGE_BITS]         = (!hit_ff && !fill) ? vic_page_ff : '0;
      out_data_in[RSP_CNT_LSB +: CNT_W]             = count_next;
      out_last_in                                   = last_ff;
      out_valid_in                                  = out_valid_ff && !rsp_tready;
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_data_ff;
   assign rsp_tlast       = out_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff) begin
         page_mem[slot] <= page_ff;
      end
      rd_data_ff <= page_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= req_tdata[PAGE_BITS-1:0];
         last_ff <= req_tlast;
      end
      occ_ff      <= occ_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      vic_ff      <= vic_in;
      vic_idx_ff  <= vic_idx_in;
      vic_rank_ff <= vic_rank_in;
      vic_page_ff <= vic_page_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      if (cmd.commit) begin
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/lrupr_checker.sv */
// Port-level checks of the LRU page replacement block and their binding.
`default_nettype none
`include "lru_page_replacement_macros.svh"

module lrupr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lrupr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                              rsp_tlast
);
   import lrupr_pkg::*;

   // a stalled result holds still
   `LRUPR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   // an accepted transaction keeps the block busy for the frame walk
   `LRUPR_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // eviction only ever happens on a fault
   `LRUPR_ASSERT_IMP(a_evict_needs_fault, clock, reset, rsp_tvalid && rsp_tdata[RSP_EVV_BIT], rsp_tdata[RSP_FAULT_BIT])
   // no eviction means a zero evicted page
   `LRUPR_ASSERT_IMP(a_evp_zero, clock, reset, rsp_tvalid && !rsp_tdata[RSP_EVV_BIT], rsp_tdata[RSP_EVP_LSB +: PAGE_BITS] == '0)
   // a fault is always counted
   `LRUPR_ASSERT_IMP(a_fault_counted, clock, reset, rsp_tvalid && rsp_tdata[RSP_FAULT_BIT], rsp_tdata[RSP_CNT_LSB +: CNT_W] != '0)

endmodule

bind lru_page_replacement lrupr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
